FILE: rtl/cleh_pkg.sv
// Shared types and constants for the console line editor with history.
// Holds the result kinds, the escape phases and the control byte codes.
// No dependencies.
package cleh_pkg;

    localparam int CHAR_W = 7;
    localparam int KIND_W = 3;

    // Kind of one display event.
    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO   = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_CLEAR  = 3'd2,
        KIND_RECALL = 3'd3,
        KIND_COMMIT = 3'd4,
        KIND_END    = 3'd5
    } kind_t;

    // Progress through an ESC [ sequence.
    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    // Received byte codes.
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_UP    = 8'h41;
    localparam logic [7:0] BYTE_CSI   = 8'h5B;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;

endpackage

FILE: rtl/cleh_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and holds until the next read request.
// No dependencies.
module cleh_ram #(
    parameter int DEPTH  = 31,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/console_line_editor_history.sv
// Terminal line editor with a newest-first command history.
// Depends on cleh_pkg and cleh_ram.
//
// Usage: each request on the s_ side carries one received terminal byte.
// The m_ side gives the display events that the byte causes, in order;
// m_tuser gives the event kind and m_tlast marks the final event of a byte.
// A byte that causes no event gives nothing on the m_ side.
//
// Timing: s_tready is high only while the sequencer is idle, so one byte
// is worked at a time. A byte is registered when taken and decoded in the
// decode state once the output register has room. Enter on a non-empty
// line and a recall give one event per cycle while the output register
// has room, paced by the single read port of the line buffer RAM or the
// history RAM. The output register lets the next byte be taken while
// the last event of the previous one still waits.
//
// Reset clears the line length, escape phase and history pointers; the
// RAM contents need no clearing. When m_tready is low the sequencer holds
// its RAM read data and waits, losing nothing.
module console_line_editor_history
    import cleh_pkg::*;
#(
    parameter int LINE_BYTES    = 32,
    parameter int HISTORY_DEPTH = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [6:0] char_value, [7] zero
    output logic [KIND_W-1:0] m_tuser,   // [2:0] kind
    output logic              m_tlast    // last
);

    localparam int LINE_CAP = LINE_BYTES - 1;
    localparam int LEN_W    = $clog2(LINE_BYTES);
    localparam int IDX_W    = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
    localparam int SLOT_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW1      = SLOT_W + 1;
    localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int HDEPTH   = HISTORY_DEPTH * LINE_CAP;
    localparam int HADR_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COMMIT,
        ST_END,
        ST_RECALL
    } state_t;

    // Sequencer and editor state.
    state_t              state_reg, state_next;
    logic [7:0]          byte_reg, byte_next;
    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [HADR_W-1:0]   hadr_reg, hadr_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    browse_reg, browse_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    // Stored line lengths, one per history slot.
    logic [LEN_W-1:0]    hlen_mem [HISTORY_DEPTH];
    logic                hlen_wr;

    // RAM ports.
    logic                line_wr_en, line_rd_en;
    logic [IDX_W-1:0]    line_wr_addr, line_rd_addr;
    logic [CHAR_W-1:0]   line_wr_data, line_rd_data;
    logic                hist_wr_en, hist_rd_en;
    logic [HADR_W-1:0]   hist_wr_addr, hist_rd_addr;
    logic [CHAR_W-1:0]   hist_rd_data;

    // Decode helpers.
    logic                out_free;
    logic [SW1-1:0]      slot_sum;
    logic [SLOT_W-1:0]   recall_slot;
    logic [LEN_W-1:0]    recall_len;
    logic [LEN_W-1:0]    idx_inc;

    cleh_ram #(
        .DEPTH  (LINE_CAP),
        .ADDR_W (IDX_W),
        .DATA_W (CHAR_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (line_rd_en),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    // History characters; commit copies the line RAM output straight in.
    cleh_ram #(
        .DEPTH  (HDEPTH),
        .ADDR_W (HADR_W),
        .DATA_W (CHAR_W)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (line_rd_data),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign idx_inc  = idx_reg + LEN_W'(1);

    // Ring slot of the entry that the next recall reads.
    assign slot_sum    = SW1'(head_reg) + SW1'(HISTORY_DEPTH - 1) - SW1'(browse_reg);
    assign recall_slot = (slot_sum >= SW1'(HISTORY_DEPTH))
                       ? SLOT_W'(slot_sum - SW1'(HISTORY_DEPTH))
                       : SLOT_W'(slot_sum);
    assign recall_len  = hlen_mem[recall_slot];

    // Sequencer next-state and RAM control.
    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        hadr_next      = hadr_reg;
        head_next      = head_reg;
        used_next      = used_reg;
        browse_next    = browse_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        hlen_wr        = 1'b0;
        line_wr_en     = 1'b0;
        line_wr_addr   = len_reg[IDX_W-1:0];
        line_wr_data   = byte_reg[CHAR_W-1:0];
        line_rd_en     = 1'b0;
        line_rd_addr   = idx_inc[IDX_W-1:0];
        hist_wr_en     = 1'b0;
        hist_wr_addr   = hadr_reg;
        hist_rd_en     = 1'b0;
        hist_rd_addr   = hadr_reg + HADR_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                // Wait for room in the output register before acting.
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (phase_reg == PH_CSI)
                    begin
                        phase_next = PH_NONE;
                        if (byte_reg == BYTE_UP && used_reg != '0 && browse_reg < used_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_CLEAR;
                            out_char_next  = '0;
                            out_last_next  = (recall_len == '0);
                            len_next       = recall_len;
                            idx_next       = '0;
                            hadr_next      = HADR_W'(recall_slot * LINE_CAP);
                            hist_rd_en     = 1'b1;
                            hist_rd_addr   = HADR_W'(recall_slot * LINE_CAP);
                            if (CNT_W'(browse_reg + CNT_W'(1)) < used_reg)
                            begin
                                browse_next = browse_reg + CNT_W'(1);
                            end
                            if (recall_len != '0)
                            begin
                                state_next = ST_RECALL;
                            end
                        end
                    end
                    else if (phase_reg == PH_ESC)
                    begin
                        phase_next = (byte_reg == BYTE_CSI) ? PH_CSI : PH_NONE;
                    end
                    else if (byte_reg == BYTE_ESC)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (byte_reg == BYTE_BS || byte_reg == BYTE_DEL)
                    begin
                        phase_next = PH_NONE;
                        if (len_reg != '0)
                        begin
                            len_next       = len_reg - LEN_W'(1);
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ERASE;
                            out_char_next  = '0;
                            out_last_next  = 1'b1;
                        end
                    end
                    else if (byte_reg == BYTE_CR || byte_reg == BYTE_LF)
                    begin
                        phase_next = PH_NONE;
                        if (len_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_END;
                            out_char_next  = '0;
                            out_last_next  = 1'b1;
                            browse_next    = '0;
                        end
                        else
                        begin
                            // Start streaming the line out of the buffer.
                            idx_next     = '0;
                            hadr_next    = HADR_W'(head_reg * LINE_CAP);
                            line_rd_en   = 1'b1;
                            line_rd_addr = '0;
                            state_next   = ST_COMMIT;
                        end
                    end
                    else
                    begin
                        phase_next = PH_NONE;
                        if (byte_reg >= BYTE_SPACE && byte_reg < BYTE_DEL
                            && len_reg < LEN_W'(LINE_CAP))
                        begin
                            line_wr_en     = 1'b1;
                            len_next       = len_reg + LEN_W'(1);
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ECHO;
                            out_char_next  = byte_reg[CHAR_W-1:0];
                            out_last_next  = 1'b1;
                        end
                    end
                end
            end

            ST_COMMIT:
            begin
                // One committed character per cycle while the output register has room, copied into history.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_COMMIT;
                    out_char_next  = line_rd_data;
                    out_last_next  = 1'b0;
                    hist_wr_en     = 1'b1;
                    hadr_next      = hadr_reg + HADR_W'(1);
                    idx_next       = idx_inc;
                    if (idx_inc < len_reg)
                    begin
                        line_rd_en = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_END;
                    end
                end
            end

            ST_END:
            begin
                // Line end; the line becomes the newest history entry.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_END;
                    out_char_next  = '0;
                    out_last_next  = 1'b1;
                    hlen_wr        = 1'b1;
                    head_next      = (head_reg == SLOT_W'(HISTORY_DEPTH - 1))
                                   ? '0 : head_reg + SLOT_W'(1);
                    if (used_reg < CNT_W'(HISTORY_DEPTH))
                    begin
                        used_next = used_reg + CNT_W'(1);
                    end
                    len_next    = '0;
                    browse_next = '0;
                    state_next  = ST_IDLE;
                end
            end

            ST_RECALL:
            begin
                // One recalled character per cycle while the output register has room, copied into the line.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_RECALL;
                    out_char_next  = hist_rd_data;
                    out_last_next  = (idx_inc == len_reg);
                    line_wr_en     = 1'b1;
                    line_wr_addr   = idx_reg[IDX_W-1:0];
                    line_wr_data   = hist_rd_data;
                    idx_next       = idx_inc;
                    if (idx_inc < len_reg)
                    begin
                        hist_rd_en = 1'b1;
                        hadr_next  = hadr_reg + HADR_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_reg      <= '0;
            phase_reg     <= PH_NONE;
            len_reg       <= '0;
            idx_reg       <= '0;
            hadr_reg      <= '0;
            head_reg      <= '0;
            used_reg      <= '0;
            browse_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_ECHO;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            hadr_reg      <= hadr_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            browse_reg    <= browse_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    // History line lengths, written when a line is stored.
    always_ff @(posedge clk)
    begin
        if (hlen_wr)
        begin
            hlen_mem[head_reg] <= len_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: dv/console_line_editor_history_test.sv
// Self-checking testbench for console_line_editor_history: random terminal bytes in,
// display events checked against a predictor of the editor and its history.
// Depends on cleh_pkg and the console_line_editor_history RTL.
`timescale 1ns / 1ps

module console_line_editor_history_test;
    import cleh_pkg::*;

    localparam int LINE_BYTES    = 32;
    localparam int HISTORY_DEPTH = 5;
    localparam int LINE_CAP      = LINE_BYTES - 1;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_ITEMS  = 260;

    // One display event as the predictor expects it.
    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } display_event_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;

    // Stimulus and expectations.
    logic [7:0]     rx_bytes_pending[$];
    display_event_t expected_events[$];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    logic           idle_on        = 1'b1;
    logic           hold_arm       = 1'b0;
    logic           hold_done      = 1'b0;
    int             hold_left      = 0;
    int             tx_gap         = 0;
    int             rx_stall       = 0;
    int             stall_draw;
    int             gen_items;

    // Predictor state of the editor.
    logic [CHAR_W-1:0] edit_chars[LINE_CAP];
    int                line_len = 0;
    phase_t            esc_phase = PH_NONE;
    logic [CHAR_W-1:0] hist_buf[HISTORY_DEPTH][LINE_CAP];
    int                hist_len[HISTORY_DEPTH];
    int                hist_head = 0;
    int                hist_used = 0;
    int                browse_pos = 0;

    // The newest event of the current byte is held back until its last flag is known.
    logic              staged_valid;
    kind_t             staged_kind;
    logic [CHAR_W-1:0] staged_char;

    console_line_editor_history #(
        .LINE_BYTES    (LINE_BYTES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function int draw_gap();
        return idle_on ? int'($urandom_range(0, 17)) : 0;
    endfunction

    function void stage_event(input kind_t kind, input logic [CHAR_W-1:0] ch);
        display_event_t ev;
        if (staged_valid)
        begin
            ev.kind = staged_kind;
            ev.ch   = staged_char;
            ev.last = 1'b0;
            expected_events.push_back(ev);
        end
        staged_valid = 1'b1;
        staged_kind  = kind;
        staged_char  = ch;
    endfunction

    // Works out the display events of one received byte and updates the editor state.
    function void predict_display_events(input logic [7:0] rx);
        display_event_t ev;
        int i;
        int slot;
        int len;
        staged_valid = 1'b0;
        case (esc_phase)
            PH_CSI:
            begin
                esc_phase = PH_NONE;
                // Only an up-arrow final recalls, and only when history holds a line.
                if (rx == BYTE_UP && hist_used != 0 && browse_pos < hist_used)
                begin
                    stage_event(KIND_CLEAR, '0);
                    slot = (hist_head + 2 * HISTORY_DEPTH - 1 - (browse_pos % HISTORY_DEPTH))
                           % HISTORY_DEPTH;
                    len = (hist_len[slot] > LINE_CAP) ? LINE_CAP : hist_len[slot];
                    for (i = 0; i < len; i++)
                    begin
                        edit_chars[i] = hist_buf[slot][i];
                        stage_event(KIND_RECALL, edit_chars[i]);
                    end
                    line_len = len;
                    if (browse_pos + 1 < hist_used)
                        browse_pos++;
                end
            end
            PH_ESC:
                esc_phase = (rx == BYTE_CSI) ? PH_CSI : PH_NONE;
            default:
            begin
                esc_phase = PH_NONE;
                if (rx == BYTE_ESC)
                    esc_phase = PH_ESC;
                else if (rx == BYTE_BS || rx == BYTE_DEL)
                begin
                    if (line_len > 0)
                    begin
                        line_len--;
                        stage_event(KIND_ERASE, '0);
                    end
                end
                else if (rx == BYTE_CR || rx == BYTE_LF)
                begin
                    for (i = 0; i < line_len; i++)
                        stage_event(KIND_COMMIT, edit_chars[i]);
                    stage_event(KIND_END, '0);
                    // A non-empty line becomes the newest history entry.
                    if (line_len > 0)
                    begin
                        for (i = 0; i < line_len; i++)
                            hist_buf[hist_head][i] = edit_chars[i];
                        hist_len[hist_head] = line_len;
                        hist_head = (hist_head + 1) % HISTORY_DEPTH;
                        if (hist_used < HISTORY_DEPTH)
                            hist_used++;
                    end
                    line_len   = 0;
                    browse_pos = 0;
                end
                else if (rx >= BYTE_SPACE && rx < BYTE_DEL && line_len < LINE_CAP)
                begin
                    edit_chars[line_len] = rx[CHAR_W-1:0];
                    line_len++;
                    stage_event(KIND_ECHO, rx[CHAR_W-1:0]);
                end
            end
        endcase
        if (staged_valid)
        begin
            ev.kind = staged_kind;
            ev.ch   = staged_char;
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
    endfunction

    task report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compares one accepted display event with the oldest expectation.
    task check_display_event();
        display_event_t ev;
        if (expected_events.size() == 0)
        begin
            report_mismatch("event with none expected, kind", m_tuser, -1);
        end
        else
        begin
            ev = expected_events.pop_front();
            if (m_tuser != ev.kind)
                report_mismatch("kind", m_tuser, ev.kind);
            if (m_tdata[6:0] != ev.ch)
                report_mismatch("char_value", m_tdata[6:0], ev.ch);
            if (m_tdata[7] != 1'b0)
                report_mismatch("tdata padding", m_tdata[7], 0);
            if (m_tlast != ev.last)
                report_mismatch("last", m_tlast, ev.last);
        end
    endtask

    task push_byte(input logic [7:0] b);
        rx_bytes_pending.push_back(b);
        gen_items++;
    endtask

    task push_escape(input logic [7:0] final_byte);
        push_byte(BYTE_ESC);
        push_byte(BYTE_CSI);
        push_byte(final_byte);
    endtask

    // Builds editing sessions: typed words, erasures, recalls, enters, and some noise.
    task push_editing_session(input int target);
        int pick;
        int n;
        int k;
        gen_items = 0;
        while (gen_items < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 6)
            begin
                // Mostly short words; now and then one long enough to fill the line.
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                    push_byte(8'($urandom_range(BYTE_SPACE, BYTE_DEL - 1)));
            end
            else if (pick < 8)
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    push_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
            end
            else if (pick < 11)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                    push_escape(BYTE_UP);
            end
            else if (pick < 15)
                push_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            else if (pick < 16)
                push_escape(8'($urandom_range(0, 255)));
            else if (pick < 17)
            begin
                push_byte(BYTE_ESC);
                push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                // Noise does not count toward the session length.
                rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Sender: offers queued bytes with random gaps; a request is held until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_display_events(s_tdata);
            if (s_tvalid && !s_tready)
            begin
                s_tvalid <= 1'b1;
            end
            else if (tx_gap != 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (rx_bytes_pending.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_bytes_pending.pop_front();
                tx_gap   <= draw_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Long receiver hold-off, run once when armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: checks accepted events and stalls a random count after each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_display_event();
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (rx_stall != 0)
            begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end
            else if (m_tvalid && m_tready)
            begin
                stall_draw = draw_gap();
                m_tready <= (stall_draw == 0);
                rx_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, stimulus phases and the final verdict.
    initial
    begin
        int phase_idx;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-history recall, backspace on an empty line, the printable
        // extremes, ignored bytes, enter on non-empty and empty lines, a broken escape,
        // an escape final other than up, then a recall of the stored line.
        push_escape(BYTE_UP);
        push_byte(BYTE_BS);
        push_byte(BYTE_DEL);
        push_byte(BYTE_SPACE);
        push_byte(8'h7E);
        push_byte(BYTE_BS);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(BYTE_CR);
        push_byte(BYTE_LF);
        push_byte(BYTE_ESC);
        push_byte(8'h78);
        push_escape(8'h42);
        push_escape(BYTE_UP);
        push_escape(BYTE_UP);
        push_byte(BYTE_CR);
        while (rx_bytes_pending.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge clk);

        // Random sessions; the receiver holds off once early so the input stalls.
        hold_arm <= 1'b1;
        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            idle_on <= (phase_idx != 2);
            push_editing_session(RANDOM_ITEMS / 4);
            while (rx_bytes_pending.size() != 0 || s_tvalid)
                @(posedge clk);
        end

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
